// ----- hdl/b64_pkg.sv -----
// ---------------------------------------------------------------------------
// b64_pkg - shared record type and function for the base64 stream encoder
// Group record passed from the front end to the character back end,
// record kinds and the standard alphabet lookup.
// ---------------------------------------------------------------------------
package b64_pkg;

  // Depth of the group queue between front and back end
  localparam int FIFO_DEPTH = 2;

  // Record kinds: how many input bytes the group carries
  localparam logic [1:0] KIND_FULL = 2'd0;  // three bytes, four characters
  localparam logic [1:0] KIND_TWO  = 2'd1;  // two bytes, three chars and '='
  localparam logic [1:0] KIND_ONE  = 2'd2;  // one byte, two chars and "=="

  localparam logic [6:0] PAD_CHAR = 7'h3D;  // '='

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_m;
    logic [7:0] byte_b;
    logic [1:0] kind;
    logic       last;
  } b64_rec_t;

  // Sextet to ASCII, A-Z a-z 0-9 + /
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    c = 7'h2F;
    case (v) inside
      [6'd0:6'd25]:  c = 7'(v) + 7'd65;
      [6'd26:6'd51]: c = 7'(v) + 7'd71;
      [6'd52:6'd61]: c = 7'(v) - 7'd4;
      6'd62:         c = 7'h2B;
      default:       c = 7'h2F;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/b64_front.sv -----
// ---------------------------------------------------------------------------
// b64_front - byte collector
// Gathers raw bytes into groups of up to three and writes one group
// record to the queue when a group completes or the message ends.
// ---------------------------------------------------------------------------
module b64_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              q_full,
  output logic              q_push,
  output b64_pkg::b64_rec_t q_rec
);

  logic [7:0] first_held;
  logic [7:0] second_held;
  logic [1:0] group_position;
  logic [7:0] first_next;
  logic [7:0] second_next;
  logic [1:0] position_next;
  logic       accept;
  logic       emit;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    emit          = 1'b0;
    first_next    = first_held;
    second_next   = second_held;
    position_next = group_position;
    q_rec.byte_a  = first_held;
    q_rec.byte_m  = second_held;
    q_rec.byte_b  = data_byte;
    q_rec.kind    = b64_pkg::KIND_FULL;
    q_rec.last    = last_byte;
    case (group_position)
      2'd1: begin
        if (last_byte) begin
          emit         = 1'b1;
          q_rec.byte_m = data_byte;
          q_rec.byte_b = 8'd0;
          q_rec.kind   = b64_pkg::KIND_TWO;
        end else begin
          second_next   = data_byte;
          position_next = 2'd2;
        end
      end
      2'd2: begin
        emit = 1'b1;
      end
      default: begin
        // start of group (an unreachable third code acts the same)
        if (last_byte) begin
          emit         = 1'b1;
          q_rec.byte_a = data_byte;
          q_rec.byte_m = 8'd0;
          q_rec.byte_b = 8'd0;
          q_rec.kind   = b64_pkg::KIND_ONE;
        end else begin
          first_next    = data_byte;
          position_next = 2'd1;
        end
      end
    endcase
    if (emit) begin
      first_next    = 8'd0;
      second_next   = 8'd0;
      position_next = 2'd0;
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_held     <= 8'd0;
      second_held    <= 8'd0;
      group_position <= 2'd0;
    end else if (accept) begin
      first_held     <= first_next;
      second_held    <= second_next;
      group_position <= position_next;
    end
  end

endmodule

// ----- hdl/b64_fifo.sv -----
// ---------------------------------------------------------------------------
// b64_fifo - group record queue
// Short first-in first-out store decoupling the byte collector from the
// character back end.
// ---------------------------------------------------------------------------
module b64_fifo #(
  parameter int DEPTH = b64_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  b64_pkg::b64_rec_t wr_rec,
  output logic              full,
  input  logic              rd_en,
  output b64_pkg::b64_rec_t rd_rec,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

  b64_pkg::b64_rec_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full   = (count == DepthCnt);
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/b64_back.sv -----
// ---------------------------------------------------------------------------
// b64_back - character serialiser
// Takes group records from the queue and issues their four characters to the
// result register, one a cycle unless pop stalls, with padding and end mark.
// ---------------------------------------------------------------------------
module b64_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  b64_pkg::b64_rec_t q_rec,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [6:0]        code_char,
  output logic              end_of_output
);

  b64_pkg::b64_rec_t cur;
  logic       busy;
  logic [1:0] idx;
  logic       out_valid;
  logic       load_out;
  logic [5:0] sextet;
  logic [6:0] char_next;
  logic       end_next;

  assign load_out = busy && (!out_valid || pop);
  assign q_pop    = !q_empty && (!busy || (load_out && idx == 2'd3));
  assign empty    = !out_valid;

  always_comb begin
    case (idx)
      2'd0:    sextet = cur.byte_a[7:2];
      2'd1:    sextet = {cur.byte_a[1:0], cur.byte_m[7:4]};
      2'd2:    sextet = {cur.byte_m[3:0], cur.byte_b[7:6]};
      default: sextet = cur.byte_b[5:0];
    endcase
    char_next = b64_pkg::sextet_char(sextet);
    if ((idx == 2'd3 && cur.kind != b64_pkg::KIND_FULL) ||
        (idx == 2'd2 && cur.kind == b64_pkg::KIND_ONE)) begin
      char_next = b64_pkg::PAD_CHAR;
    end
    end_next = (idx == 2'd3) && (cur.kind != b64_pkg::KIND_FULL || cur.last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (load_out) begin
        idx <= idx + 2'd1;
        if (idx == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rec;
    end
    if (load_out) begin
      code_char     <= char_next;
      end_of_output <= end_next;
    end
  end

endmodule

// ----- hdl/base64_stream_encoder_unit.sv -----
// ---------------------------------------------------------------------------
// base64_stream_encoder_unit - base64 encoder for a byte stream
// Turns raw message bytes into standard base64 characters with padding.
// ---------------------------------------------------------------------------
// Usage:
//  - Input queue: present data_byte/last_byte and raise push; the request
//    is taken on a clock edge with push high and full low. last_byte marks
//    the final byte of a message and flushes the pending group.
//  - Result queue: while empty is low, code_char/end_of_output hold the
//    oldest character; pop high at an edge with empty low takes it.
//    end_of_output marks the final character of a message.
//  - Path: the record of a completed or ended group passes the group
//    queue and the back-end record register before its first character
//    reaches the result register.
//  - Flow: a byte that does not close a group is taken whenever full is low;
//    each group sends four characters through the one-character result
//    register, so a sustained stream is bound by the back-end serialiser.
//  - When the receiver stalls, the result register holds; the group queue
//    (FIFO_DEPTH records) fills and full then rises.
//  - Reset (rst, synchronous): clears held bytes and group position and
//    empties queue and result register; empty goes high, full low.
// ---------------------------------------------------------------------------
module base64_stream_encoder_unit #(
  parameter int FIFO_DEPTH = b64_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] code_char,
  output logic       end_of_output
);

  // front end to queue
  b64_pkg::b64_rec_t wr_rec;
  logic              wr_en;
  logic              q_full;
  // queue to back end
  b64_pkg::b64_rec_t rd_rec;
  logic              rd_en;
  logic              q_empty;

  // front: collects bytes, classifies the group on completion or flush
  b64_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (wr_en),
    .q_rec     (wr_rec)
  );

  // short queue of group records so each side stalls on its own
  b64_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_rec (wr_rec),
    .full   (q_full),
    .rd_en  (rd_en),
    .rd_rec (rd_rec),
    .empty  (q_empty)
  );

  // back: four characters per record into the result register
  b64_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_rec         (rd_rec),
    .q_pop         (rd_en),
    .pop           (pop),
    .empty         (empty),
    .code_char     (code_char),
    .end_of_output (end_of_output)
  );

endmodule

// ----- hdl/b64_checker.sv -----
// ---------------------------------------------------------------------------
// b64_checker - port-level checks for the base64 stream encoder
// Watches the top-level queues; bound to every instance of the top level.
// ---------------------------------------------------------------------------
module b64_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [6:0] code_char,
  input logic       end_of_output
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // reset frees the input side
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input queue full after reset");

  // a waiting result that is not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(code_char) && $stable(end_of_output)))
    else $error("stalled result changed");

  // every result is an alphabet character or padding
  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((code_char >= 7'h41 && code_char <= 7'h5A) ||
                (code_char >= 7'h61 && code_char <= 7'h7A) ||
                (code_char >= 7'h30 && code_char <= 7'h39) ||
                code_char == 7'h2B || code_char == 7'h2F || code_char == 7'h3D))
    else $error("illegal output character");

endmodule

bind base64_stream_encoder_unit b64_checker u_b64_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .code_char     (code_char),
  .end_of_output (end_of_output)
);

// ----- test/b64_char_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64_char_checker - scoreboard for the base64 stream encoder
// Watches the byte and character queues, predicts the characters of each
// accepted request and compares every popped character with the oldest one.
// ---------------------------------------------------------------------------
module b64_char_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [6:0] code_char,
  input  logic       end_of_output,
  output int         fail_count,
  output int         chars_due
);

  typedef struct packed {
    logic [6:0] ch;
    logic       eom;
  } b64_char_t;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int SLOTS = 256;

  // ring of predicted characters, oldest at rd_idx
  b64_char_t  pending_chars [SLOTS];
  logic [7:0] wr_idx;
  logic [7:0] rd_idx;
  int         pending_count;
  b64_char_t  oldest;
  logic [7:0] held_a;
  logic [7:0] held_b;
  logic [1:0] held_count;

  function automatic logic [6:0] to_char(input logic [5:0] s);
    return ALPHABET[8*(63-s) +: 7];
  endfunction

  task automatic queue_char(input b64_char_t c);
    pending_chars[wr_idx] = c;
    wr_idx                = wr_idx + 8'd1;
    pending_count++;
  endtask

  // one byte in: either held, or a group of four characters queued
  task automatic encode_byte(input logic [7:0] b, input logic l);
    logic [5:0] s0, s1, s2, s3;
    logic       pad2, pad3, emit;
    s0 = '0; s1 = '0; s2 = '0; s3 = '0;
    pad2 = 1'b0; pad3 = 1'b0; emit = 1'b1;
    case (held_count)
      2'd1: begin
        if (!l) begin
          held_b     = b;
          held_count = 2'd2;
          emit       = 1'b0;
        end else begin
          s0   = held_a[7:2];
          s1   = {held_a[1:0], b[7:4]};
          s2   = {b[3:0], 2'b00};
          pad3 = 1'b1;
        end
      end
      2'd2: begin
        s0 = held_a[7:2];
        s1 = {held_a[1:0], held_b[7:4]};
        s2 = {held_b[3:0], b[7:6]};
        s3 = b[5:0];
      end
      default: begin
        if (!l) begin
          held_a     = b;
          held_count = 2'd1;
          emit       = 1'b0;
        end else begin
          s0   = b[7:2];
          s1   = {b[1:0], 4'b0000};
          pad2 = 1'b1;
          pad3 = 1'b1;
        end
      end
    endcase
    if (emit) begin
      queue_char(b64_char_t'{to_char(s0), 1'b0});
      queue_char(b64_char_t'{to_char(s1), 1'b0});
      queue_char(b64_char_t'{pad2 ? b64_pkg::PAD_CHAR : to_char(s2), 1'b0});
      queue_char(b64_char_t'{pad3 ? b64_pkg::PAD_CHAR : to_char(s3), l});
      held_a     = '0;
      held_b     = '0;
      held_count = 2'd0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wr_idx        = '0;
      rd_idx        = '0;
      pending_count = 0;
      held_a        = '0;
      held_b        = '0;
      held_count    = 2'd0;
      fail_count    = 0;
    end else begin
      if (pop && !empty) begin
        if (pending_count == 0) begin
          $display("%0t: unexpected character, expected none, actual %h eom %b",
                   $time, code_char, end_of_output);
          fail_count++;
        end else begin
          oldest = pending_chars[rd_idx];
          rd_idx = rd_idx + 8'd1;
          pending_count--;
          if (code_char !== oldest.ch) begin
            $display("%0t: code_char mismatch, expected %h, actual %h",
                     $time, oldest.ch, code_char);
            fail_count++;
          end
          if (end_of_output !== oldest.eom) begin
            $display("%0t: end_of_output mismatch, expected %b, actual %b",
                     $time, oldest.eom, end_of_output);
            fail_count++;
          end
        end
      end
      if (push && !full)
        encode_byte(data_byte, last_byte);
    end
    chars_due <= pending_count;
  end

endmodule

// ----- test/base64_stream_encoder_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_encoder_unit_tb - testbench for the base64 stream encoder
// Directed messages for padding and alphabet corners, then random messages
// with random idling on both queues; the checker scores every character.
// ---------------------------------------------------------------------------
module base64_stream_encoder_unit_tb;

  localparam int BYTE_TARGET    = 430;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request moving
  localparam int IDLE_PCT       = 11;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty;
  logic       pop;
  logic [6:0] code_char;
  logic       end_of_output;

  int   fail_count;
  int   chars_due;
  int   bytes_sent;
  int   stall_cycles;
  int   msg_len;
  logic steady;  // no idling on either side while set

  base64_stream_encoder_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .empty         (empty),
    .pop           (pop),
    .code_char     (code_char),
    .end_of_output (end_of_output)
  );

  b64_char_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .empty         (empty),
    .pop           (pop),
    .code_char     (code_char),
    .end_of_output (end_of_output),
    .fail_count    (fail_count),
    .chars_due     (chars_due)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver: pop is redrawn every falling edge, stalls about 11 in 100
  always @(negedge clk) begin
    pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog: any cycle that moves a request on either side clears it
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("base64_stream_encoder_unit_tb failed");
        $finish;
      end
    end
  end

  // one byte request; push stays high into the next request unless a gap
  // is drawn, so back-to-back pushes never drop for a step
  task automatic send_byte(input logic [7:0] b, input logic l);
    @(negedge clk);
    while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  // a message of n random bytes, last one flagged
  task automatic send_random_msg(input int n);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom), i == n - 1);
  endtask

  initial begin
    rst          = 1'b1;
    push         = 1'b0;
    data_byte    = '0;
    last_byte    = 1'b0;
    steady       = 1'b0;
    bytes_sent   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single byte flush: two chars and double pad, both extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // two byte flush: three chars and one pad
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // group completed on the last byte, no padding
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // full group mid-message, then a one byte tail; hits '+'
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'h4D, 1'b1);
    // digits and letter boundaries, two byte tail after a group
    send_byte(8'hF8, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h3E, 1'b0);
    send_byte(8'hFC, 1'b0);
    send_byte(8'h0A, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b1);

    // random messages, mostly short so every tail length shows up often
    while (bytes_sent < BYTE_TARGET) begin
      steady = (bytes_sent >= 180) && (bytes_sent < 280);
      if ($urandom_range(0, 9) < 8)
        msg_len = $urandom_range(1, 7);
      else
        msg_len = $urandom_range(8, 24);
      send_random_msg(msg_len);
    end
    steady = 1'b0;

    @(negedge clk);
    push <= 1'b0;

    // drain, then let the back end settle
    while (chars_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && chars_due == 0)
      $display("base64_stream_encoder_unit_tb passed");
    else
      $display("base64_stream_encoder_unit_tb failed");
    $finish;
  end

endmodule
